### src/apdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aged priority dispatch queue package
// Shared sizes, weights, operation and status codes, and the interface types
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package apdq_pkg;

   localparam int QUEUE_DEPTH    = 128;
   localparam int UNIT_POOL_SIZE = 32;

   localparam int ADDR_W   = $clog2(QUEUE_DEPTH);
   localparam int OCC_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int UNIT_W   = 5;
   localparam int UCNT_W   = $clog2(UNIT_POOL_SIZE + 1);
   localparam int CSR_W    = 6;
   localparam int FUNC_W   = 2;
   localparam int SEV_W    = 4;
   localparam int VIC_W    = 10;
   localparam int STATUS_W = 3;
   localparam int ID_W     = 8;
   localparam int COUNT_W  = 8;
   localparam int STAMP_W  = 32;
   localparam int BASE_W   = 15;
   localparam int RANK_W   = STAMP_W + 1;

   localparam int SEV_WEIGHT = 50;
   localparam int VIC_WEIGHT = 20;

   localparam logic [CSR_W-1:0] UNIT_COUNT_RESET = CSR_W'(1);

   typedef enum logic [FUNC_W-1:0] {
      FN_REPORT   = 2'd0,
      FN_DISPATCH = 2'd1,
      FN_RELEASE  = 2'd2,
      FN_TICK     = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK           = 3'd0,
      STAT_FULL         = 3'd1,
      STAT_NO_UNIT      = 3'd2,
      STAT_EMPTY        = 3'd3,
      STAT_ALREADY_FREE = 3'd4,
      STAT_NO_SUCH_UNIT = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_MOVE_RD,
      ST_MOVE_WR
   } ctrl_state_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [BASE_W-1:0]  base;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic exec_op;
      logic start_scan;
      logic scan_issue;
      logic move_read;
      logic move_commit;
   } cmd_type;

   typedef struct packed {
      logic dispatch_go;
      logic scan_last;
      logic pipe_empty;
   } stat_type;

endpackage

### src/apdq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module apdq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/apdq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aged priority dispatch queue controller
// Sequences the operations done from idle and the dispatch scan, drain and move.
// ----------------------------------------------------------------------------
module apdq_ctrl import apdq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  func_type func,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           take_dispatch;

   assign take_dispatch = (func == FN_DISPATCH) && stat.dispatch_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && take_dispatch) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (stat.pipe_empty) begin
               state_in = ST_MOVE_RD;
            end
         end
         ST_MOVE_RD: state_in = ST_MOVE_WR;
         ST_MOVE_WR: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.start_scan = take_dispatch;
               cmd.exec_op    = !take_dispatch;
            end
         end
         ST_SCAN:    cmd.scan_issue  = 1'b1;
         ST_DRAIN:   cmd             = '0;
         ST_MOVE_RD: cmd.move_read   = 1'b1;
         ST_MOVE_WR: cmd.move_commit = 1'b1;
         default:    cmd             = '0;
      endcase
   end

endmodule

### src/apdq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aged priority dispatch queue datapath
// Entry RAM, occupancy, time, unit pool, rank pipeline and result registers.
// ----------------------------------------------------------------------------
module apdq_dp import apdq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  func_type            func,
   input  logic [SEV_W-1:0]    severity,
   input  logic [VIC_W-1:0]    victims,
   input  logic [UNIT_W-1:0]   unit_index,
   input  logic                csr_we,
   input  logic [CSR_W-1:0]    csr_wdata,
   output logic                rsp_strobe,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ID_W-1:0]     rsp_request_id,
   output logic [UNIT_W-1:0]   rsp_served_unit,
   output logic [COUNT_W-1:0]  rsp_queue_count
);

   logic [OCC_W-1:0]     occ_ff, occ_in, occ_m1;
   logic [STAMP_W-1:0]   now_ff, now_in;
   logic [UNIT_POOL_SIZE-1:0] busy_ff, busy_in;
   logic [CSR_W-1:0]     ucount_ff, ucount_in;
   logic [UNIT_W-1:0]    free_ff, free_in;
   logic [ADDR_W-1:0]    cnt_ff, cnt_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [ADDR_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                 rank_vld_ff, rank_vld_in;
   logic [RANK_W-1:0]    rank_ff, rank_in;
   logic [ADDR_W-1:0]    rank_idx_ff, rank_idx_in;
   logic [ID_W-1:0]      rank_id_ff, rank_id_in;
   logic [RANK_W-1:0]    best_ff, best_in;
   logic [ADDR_W-1:0]    best_idx_ff, best_idx_in;
   logic [ID_W-1:0]      best_id_ff, best_id_in;
   logic                 strobe_ff, strobe_in;
   status_type           status_ff, status_in;
   logic [ID_W-1:0]      rid_ff, rid_in;
   logic [UNIT_W-1:0]    unit_ff, unit_in;
   logic [COUNT_W-1:0]   count_ff, count_in;

   logic [UCNT_W-1:0]    units_n;
   logic                 free_found;
   logic [UNIT_W-1:0]    free_idx;
   logic [STAMP_W-1:0]   age;
   logic [BASE_W-1:0]    new_base;
   entry_type            rd_entry;
   entry_type            new_entry;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [$bits(entry_type)-1:0] wr_data;
   logic [ADDR_W-1:0]    rd_addr;
   logic [$bits(entry_type)-1:0] rd_data;

   apdq_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign units_n  = (ucount_ff > UNIT_POOL_SIZE) ? UCNT_W'(UNIT_POOL_SIZE)
                                                  : UCNT_W'(ucount_ff);
   assign occ_m1   = occ_ff - OCC_W'(1);
   assign rd_entry = entry_type'(rd_data);
   assign age      = now_ff - rd_entry.stamp;
   assign new_base = BASE_W'(severity * SEV_WEIGHT + victims * VIC_WEIGHT);
   assign rd_addr  = cmd.move_read ? occ_m1[ADDR_W-1:0] : cnt_ff;

   always_comb begin
      new_entry.id    = ID_W'(occ_ff + OCC_W'(1));
      new_entry.base  = new_base;
      new_entry.stamp = now_ff;
   end

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int u = UNIT_POOL_SIZE - 1; u >= 0; u--) begin
         if ((u < units_n) && !busy_ff[u]) begin
            free_found = 1'b1;
            free_idx   = UNIT_W'(u);
         end
      end
   end

   always_comb begin
      stat.dispatch_go = free_found && (occ_ff != '0);
      stat.scan_last   = ({1'b0, cnt_ff} == occ_m1);
      stat.pipe_empty  = !rd_vld_ff && !rank_vld_ff;
   end

   always_comb begin
      occ_in      = occ_ff;
      now_in      = now_ff;
      busy_in     = busy_ff;
      ucount_in   = ucount_ff;
      free_in     = free_ff;
      cnt_in      = cnt_ff;
      rd_vld_in   = cmd.scan_issue;
      rd_idx_in   = cnt_ff;
      rank_vld_in = rd_vld_ff;
      rank_in     = {1'b0, age} + RANK_W'(rd_entry.base);
      rank_idx_in = rd_idx_ff;
      rank_id_in  = rd_entry.id;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      best_id_in  = best_id_ff;
      strobe_in   = 1'b0;
      status_in   = status_ff;
      rid_in      = rid_ff;
      unit_in     = unit_ff;
      count_in    = count_ff;
      wr_en       = 1'b0;
      wr_addr     = occ_ff[ADDR_W-1:0];
      wr_data     = new_entry;

      if (csr_we) begin
         ucount_in = csr_wdata;
      end

      if (cmd.scan_issue) begin
         cnt_in = cnt_ff + ADDR_W'(1);
      end

      if (rank_vld_ff && ((rank_idx_ff == '0) || (rank_ff > best_ff))) begin
         best_in     = rank_ff;
         best_idx_in = rank_idx_ff;
         best_id_in  = rank_id_ff;
      end

      if (cmd.start_scan) begin
         cnt_in  = '0;
         free_in = free_idx;
      end

      if (cmd.exec_op) begin
         strobe_in = 1'b1;
         status_in = STAT_OK;
         rid_in    = '0;
         unit_in   = '0;
         unique case (func)
            FN_REPORT: begin
               if (occ_ff >= QUEUE_DEPTH) begin
                  status_in = STAT_FULL;
               end else begin
                  rid_in = new_entry.id;
                  occ_in = occ_ff + OCC_W'(1);
                  wr_en  = 1'b1;
               end
            end
            FN_DISPATCH: begin
               status_in = free_found ? STAT_EMPTY : STAT_NO_UNIT;
            end
            FN_RELEASE: begin
               unit_in = unit_index;
               if (unit_index >= units_n) begin
                  status_in = STAT_NO_SUCH_UNIT;
               end else if (!busy_ff[unit_index]) begin
                  status_in = STAT_ALREADY_FREE;
               end else begin
                  busy_in[unit_index] = 1'b0;
               end
            end
            FN_TICK: begin
               now_in = now_ff + STAMP_W'(1);
            end
            default: begin
               status_in = STAT_OK;
            end
         endcase
         count_in = COUNT_W'(occ_in);
      end

      if (cmd.move_commit) begin
         wr_en            = 1'b1;
         wr_addr          = best_idx_ff;
         wr_data          = rd_data;
         occ_in           = occ_m1;
         busy_in[free_ff] = 1'b1;
         strobe_in        = 1'b1;
         status_in        = STAT_OK;
         rid_in           = best_id_ff;
         unit_in          = free_ff;
         count_in         = COUNT_W'(occ_m1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff      <= '0;
         now_ff      <= '0;
         busy_ff     <= '0;
         ucount_ff   <= UNIT_COUNT_RESET;
         rd_vld_ff   <= 1'b0;
         rank_vld_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         occ_ff      <= occ_in;
         now_ff      <= now_in;
         busy_ff     <= busy_in;
         ucount_ff   <= ucount_in;
         rd_vld_ff   <= rd_vld_in;
         rank_vld_ff <= rank_vld_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      free_ff     <= free_in;
      cnt_ff      <= cnt_in;
      rd_idx_ff   <= rd_idx_in;
      rank_ff     <= rank_in;
      rank_idx_ff <= rank_idx_in;
      rank_id_ff  <= rank_id_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      best_id_ff  <= best_id_in;
      status_ff   <= status_in;
      rid_ff      <= rid_in;
      unit_ff     <= unit_in;
      count_ff    <= count_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_request_id  = rid_ff;
   assign rsp_served_unit = unit_ff;
   assign rsp_queue_count = count_ff;

endmodule

### src/aged_priority_dispatch_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aged priority dispatch queue
// Unsorted request array with a pool of server units; dispatch picks the
// waiting request of highest aged priority for the lowest free unit.
// ----------------------------------------------------------------------------
// Channel    Ports                                         Handshake
// request    req_func, req_severity, req_victims,          start & !busy
//            req_unit_index
// result     rsp_status, rsp_request_id,                   rsp_strobe, one cycle
//            rsp_served_unit, rsp_queue_count
// config     csr_wdata (unit count)                        csr_valid & csr_ready
//
// Report, release, tick and a failed dispatch give their result in the cycle
// after acceptance, and busy stays low.
// A dispatch that serves a request holds busy through scan, drain and move:
// the entry RAM is scanned one entry per cycle through its single read port.
// Reset is synchronous and leaves the entry RAM unwritten; no clearing pass.
// The result has no back pressure and each beat is shown for one cycle.
// ----------------------------------------------------------------------------
module aged_priority_dispatch_queue import apdq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [SEV_W-1:0]    req_severity,
   input  logic [VIC_W-1:0]    req_victims,
   input  logic [UNIT_W-1:0]   req_unit_index,
   output logic                rsp_strobe,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ID_W-1:0]     rsp_request_id,
   output logic [UNIT_W-1:0]   rsp_served_unit,
   output logic [COUNT_W-1:0]  rsp_queue_count,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CSR_W-1:0]    csr_wdata
);

   cmd_type  cmd;
   stat_type stat;
   func_type func;

   assign func      = func_type'(req_func);
   assign csr_ready = !busy;

   apdq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .func  (func),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   apdq_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .func            (func),
      .severity        (req_severity),
      .victims         (req_victims),
      .unit_index      (req_unit_index),
      .csr_we          (csr_valid && csr_ready),
      .csr_wdata       (csr_wdata),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_request_id  (rsp_request_id),
      .rsp_served_unit (rsp_served_unit),
      .rsp_queue_count (rsp_queue_count)
   );

   a_accept_answered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_strobe || busy))
      else $error("Accepted beat neither answered nor in dispatch.");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("Result beat while a dispatch is in progress.");

   a_dispatch_done: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (rsp_strobe && (rsp_status == STAT_OK)))
      else $error("Dispatch finished without a successful result beat.");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_queue_count <= QUEUE_DEPTH))
      else $error("Queue count beyond the queue depth.");

endmodule
